@@ design/pdm_pkg.sv @@
// ----------------------------------------------------------------------------
// pdm_pkg: shared types, codes and helpers
// Packet codes, register indexes, reset values, the tick job record and the
// pitch-bend scaling function used by the knob-to-MIDI event core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdm_pkg;

  // USB-MIDI code index and MIDI status values.
  localparam logic [3:0] CIN_CONTROL = 4'hB;
  localparam logic [7:0] ST_CONTROL  = 8'hB0;
  localparam logic [3:0] CIN_BEND    = 4'hE;
  localparam logic [7:0] ST_BEND     = 8'hE0;

  // Configuration register indexes.
  localparam int          CFG_IDX_W          = 3;
  localparam int          CFG_DATA_W         = 16;
  localparam logic [2:0]  REG_SCAN_INTERVAL  = 3'd0;
  localparam logic [2:0]  REG_COARSE_THRESH  = 3'd1;
  localparam logic [2:0]  REG_FINE_THRESH    = 3'd2;
  localparam logic [2:0]  REG_VOLUME_CC      = 3'd3;
  localparam logic [2:0]  REG_MODULATION_CC  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_SCAN_INTERVAL  = 16'd50;
  localparam logic [6:0]  RST_COARSE_THRESH  = 7'd4;
  localparam logic [9:0]  RST_FINE_THRESH    = 10'd32;
  localparam logic [6:0]  RST_VOLUME_CC      = 7'd7;
  localparam logic [6:0]  RST_MODULATION_CC  = 7'd1;

  // Default depth of the job queue between front and back.
  localparam int          JOB_DEPTH_DEF      = 2;

  typedef struct packed {
    logic [15:0] scan_interval;
    logic [6:0]  coarse_threshold;
    logic [9:0]  fine_threshold;
    logic [6:0]  volume_cc;
    logic [6:0]  modulation_cc;
  } cfg_t;

  // One scan that produced at least one packet.
  typedef struct packed {
    logic       send_vol;
    logic       send_pit;
    logic       send_mod;
    logic [6:0] vol;
    logic [9:0] pit;
    logic [6:0] mod;
    logic [6:0] vol_cc;
    logic [6:0] mod_cc;
  } job_t;

  // floor(pit * 16383 / 1023) = 16*pit + floor(15*pit / 1023).
  // The small quotient is formed as x >> 10 with a single correction step.
  function automatic logic [13:0] bend_of(input logic [9:0] pit);
    logic [13:0] x;
    logic [3:0]  q0;
    logic [10:0] r;
    logic [3:0]  q;
    x  = {pit, 4'b0000} - {4'b0000, pit};
    q0 = x[13:10];
    r  = {1'b0, x[9:0]} + {7'd0, q0};
    q  = (r >= 11'd1023) ? q0 + 4'd1 : q0;
    return {pit, 4'b0000} + {10'd0, q};
  endfunction

endpackage

@@ design/pdm_front.sv @@
// ----------------------------------------------------------------------------
// pdm_front: tick intake and deadband classification
// Keeps the scan counter and the knob references, and queues one job for
// every scan in which at least one knob left its deadband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdm_front
  import pdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] in_volume_reading,
  input  logic [9:0] in_pitch_reading,
  input  logic [9:0] in_modulation_reading,
  input  logic       job_full,
  output logic       job_push,
  output job_t       job_data
);

  logic        primed_r, primed_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [6:0]  vol_ref_r, vol_ref_nxt;
  logic [9:0]  pit_ref_r, pit_ref_nxt;
  logic [6:0]  mod_ref_r, mod_ref_nxt;

  logic        accept;
  logic [6:0]  vol7, mod7;
  logic [15:0] tick_inc;
  logic        scan;
  logic [6:0]  dv, dm;
  logic [9:0]  dp;
  logic        send_v, send_p, send_m;

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;

  assign vol7 = in_volume_reading[9:3];
  assign mod7 = in_modulation_reading[9:3];

  assign tick_inc = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign scan     = (tick_inc >= cfg.scan_interval);

  assign dv = (vol7 > vol_ref_r) ? vol7 - vol_ref_r : vol_ref_r - vol7;
  assign dm = (mod7 > mod_ref_r) ? mod7 - mod_ref_r : mod_ref_r - mod7;
  assign dp = (in_pitch_reading > pit_ref_r) ? in_pitch_reading - pit_ref_r
                                              : pit_ref_r - in_pitch_reading;

  assign send_v = scan && (dv > cfg.coarse_threshold);
  assign send_p = scan && (dp > cfg.fine_threshold);
  assign send_m = scan && (dm > cfg.coarse_threshold);

  assign job_push = accept && primed_r && (send_v || send_p || send_m);

  always_comb begin
    job_data.send_vol = send_v;
    job_data.send_pit = send_p;
    job_data.send_mod = send_m;
    job_data.vol      = vol7;
    job_data.pit      = in_pitch_reading;
    job_data.mod      = mod7;
    job_data.vol_cc   = cfg.volume_cc;
    job_data.mod_cc   = cfg.modulation_cc;
  end

  always_comb begin
    primed_nxt  = primed_r;
    tick_nxt    = tick_r;
    vol_ref_nxt = vol_ref_r;
    pit_ref_nxt = pit_ref_r;
    mod_ref_nxt = mod_ref_r;
    if (accept) begin
      if (!primed_r) begin
        // The first tick only loads the references.
        primed_nxt  = 1'b1;
        tick_nxt    = 16'd0;
        vol_ref_nxt = vol7;
        pit_ref_nxt = in_pitch_reading;
        mod_ref_nxt = mod7;
      end else begin
        tick_nxt = scan ? 16'd0 : tick_inc;
        if (send_v) vol_ref_nxt = vol7;
        if (send_p) pit_ref_nxt = in_pitch_reading;
        if (send_m) mod_ref_nxt = mod7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r  <= 1'b0;
      tick_r    <= 16'd0;
      vol_ref_r <= 7'd0;
      pit_ref_r <= 10'd0;
      mod_ref_r <= 7'd0;
    end else begin
      primed_r  <= primed_nxt;
      tick_r    <= tick_nxt;
      vol_ref_r <= vol_ref_nxt;
      pit_ref_r <= pit_ref_nxt;
      mod_ref_r <= mod_ref_nxt;
    end
  end

  // A job is never queued from the priming tick.
  a_no_push_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> primed_r)
    else $error("job queued before references were loaded");

endmodule

@@ design/pdm_queue.sv @@
// ----------------------------------------------------------------------------
// pdm_queue: job queue
// Small first-in first-out store of scan jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdm_queue
  import pdm_pkg::*;
#(
  parameter int DEPTH = JOB_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("job queue read while empty");

endmodule

@@ design/pdm_back.sv @@
// ----------------------------------------------------------------------------
// pdm_back: packet sequencer
// Takes one job at a time and sends its packets through a registered output
// stage in the order volume, pitch, modulation, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdm_back
  import pdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job_head,
  input  logic       job_empty,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_code_index,
  output logic [7:0] out_status_byte,
  output logic [6:0] out_data_one,
  output logic [6:0] out_data_two,
  output logic       out_last_of_run
);

  job_t       job_r;
  logic [2:0] rem_r, rem_nxt;
  logic [2:0] rem_after;
  logic       load;
  logic [13:0] bend;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] cin_r, cin_nxt;
  logic [7:0] st_r, st_nxt;
  logic [6:0] d1_r, d1_nxt;
  logic [6:0] d2_r, d2_nxt;
  logic       last_r, last_nxt;

  // rem_r bit 2 is volume, bit 1 pitch, bit 0 modulation.
  assign load = (!out_valid_r || !out_stall) && (rem_r != 3'b000);
  assign bend = bend_of(job_r.pit);

  always_comb begin
    rem_after = rem_r;
    cin_nxt   = cin_r;
    st_nxt    = st_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    if (rem_r[2]) begin
      rem_after[2] = 1'b0;
      cin_nxt = CIN_CONTROL;
      st_nxt  = ST_CONTROL;
      d1_nxt  = job_r.vol_cc;
      d2_nxt  = job_r.vol;
    end else if (rem_r[1]) begin
      rem_after[1] = 1'b0;
      cin_nxt = CIN_BEND;
      st_nxt  = ST_BEND;
      d1_nxt  = bend[6:0];
      d2_nxt  = bend[13:7];
    end else begin
      rem_after[0] = 1'b0;
      cin_nxt = CIN_CONTROL;
      st_nxt  = ST_CONTROL;
      d1_nxt  = job_r.mod_cc;
      d2_nxt  = job_r.mod;
    end
    last_nxt = (rem_after == 3'b000);
  end

  assign job_pop = !job_empty &&
                   ((rem_r == 3'b000) || (load && (rem_after == 3'b000)));

  always_comb begin
    rem_nxt = rem_r;
    if (load) rem_nxt = rem_after;
    if (job_pop) rem_nxt = {job_head.send_vol, job_head.send_pit, job_head.send_mod};
    out_valid_nxt = out_valid_r;
    if (load)             out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job_head;
    if (load) begin
      cin_r  <= cin_nxt;
      st_r   <= st_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_index  = cin_r;
  assign out_status_byte = st_r;
  assign out_data_one    = d1_r;
  assign out_data_two    = d2_r;
  assign out_last_of_run = last_r;

  // Packets of one run follow each other without a gap.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !last_r) |=> out_valid_r)
    else $error("run of packets broken before its last packet");

endmodule

@@ design/pot_deadband_to_midi_events_core.sv @@
// ----------------------------------------------------------------------------
// pot_deadband_to_midi_events_core: knob deadband to USB-MIDI event core
// Turns millisecond ticks of three knob samples into control-change and
// pitch-bend packets, with a configurable scan interval and deadbands.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one request per millisecond tick with the volume,
// pitch and modulation samples. A request is taken when in_valid is high and
// in_stall is low. The result channel gives zero to three packets per tick,
// in the order volume, pitch, modulation; out_last_of_run marks the final
// packet of the tick. The configuration channel writes one register per
// request (cfg_valid and cfg_ready high); cfg_ready is always high, and
// writes should only be made while the core is idle.
// Flow: a taken tick passes through the job queue and the back end's job
// register before its first packet is loaded into the output register. A
// tick is taken every cycle while the job queue has room; the back end
// sends one packet per cycle while the receiver does not stall.
// Reset (synchronous, active low) restores the register defaults, clears
// the references and the scan counter; the first tick afterwards only loads
// references. When the receiver stalls, the output packet holds, the queue
// fills, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pot_deadband_to_midi_events_core
  import pdm_pkg::*;
#(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [9:0]            in_volume_reading,
  input  logic [9:0]            in_pitch_reading,
  input  logic [9:0]            in_modulation_reading,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_code_index,
  output logic [7:0]            out_status_byte,
  output logic [6:0]            out_data_one,
  output logic [6:0]            out_data_two,
  output logic                  out_last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic cfg_write;

  logic job_push, job_pop, job_full, job_empty;
  job_t job_in, job_head;

  // Register writes are always taken; an index past the list is dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_SCAN_INTERVAL: cfg_nxt.scan_interval    = cfg_data;
        REG_COARSE_THRESH: cfg_nxt.coarse_threshold = cfg_data[6:0];
        REG_FINE_THRESH:   cfg_nxt.fine_threshold   = cfg_data[9:0];
        REG_VOLUME_CC:     cfg_nxt.volume_cc        = cfg_data[6:0];
        REG_MODULATION_CC: cfg_nxt.modulation_cc    = cfg_data[6:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_interval    <= RST_SCAN_INTERVAL;
      cfg_r.coarse_threshold <= RST_COARSE_THRESH;
      cfg_r.fine_threshold   <= RST_FINE_THRESH;
      cfg_r.volume_cc        <= RST_VOLUME_CC;
      cfg_r.modulation_cc    <= RST_MODULATION_CC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies each tick and queues scans that need packets.
  pdm_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_volume_reading     (in_volume_reading),
    .in_pitch_reading      (in_pitch_reading),
    .in_modulation_reading (in_modulation_reading),
    .job_full              (job_full),
    .job_push              (job_push),
    .job_data              (job_in)
  );

  // The queue lets the front keep taking ticks while packets drain.
  pdm_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .head      (job_head),
    .full      (job_full),
    .empty     (job_empty)
  );

  // The back end turns each job into its packets.
  pdm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_head        (job_head),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_index  (out_code_index),
    .out_status_byte (out_status_byte),
    .out_data_one    (out_data_one),
    .out_data_two    (out_data_two),
    .out_last_of_run (out_last_of_run)
  );

endmodule
